>>> rtl/hfla_pkg.sv
// Shared types and constants for the handle free-list allocator.
package hfla_pkg;

  localparam int HANDLE_W     = 11;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 1024;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd2;

  typedef struct packed {
    logic                operation;
    logic [HANDLE_W-1:0] handle_in;
  } in_item_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle_out;
    logic [STATUS_W-1:0] status;
  } out_item_t;

endpackage

>>> rtl/hfla_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module hfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/handle_free_list_allocator_top.sv
// Top level of the handle free-list allocator: control, head, count and link RAM.
//
// Hands out handles 1..CAPACITY. An allocate (operation 0) pops the most
// recently freed handle from a LIFO free list kept in a link RAM, or issues
// the next never-used handle when the list is empty; with nothing left it
// returns status exhausted and handle 0. A free (operation 1) pushes a handle
// back; a handle of 0 or one never issued returns status invalid.
//
// Input channel: in_valid / in_stall / in_data. Output channel: out_valid /
// out_stall / out_data. A transfer happens at an edge with valid high and
// stall low. Every input item gives exactly one result.
//
// An item runs in two steps: the input transfer reads the link entry under
// the list head from the RAM (registered read port), and the work state
// updates head, count and RAM and loads the output register. The next
// item is taken while a result is still waiting in the output register, as
// long as that result is transferred in the same cycle. While the receiver
// stalls, the result holds and in_stall stays high once the block has
// finished its item.
// Reset (rst, synchronous) empties the list and clears the issued count;
// the link RAM needs no clearing, since only written entries are read.
module handle_free_list_allocator_top
  import hfla_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int ADDR_W = $clog2(CAPACITY);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WORK = 1'b1;

  logic                state;
  logic [HANDLE_W-1:0] free_head;
  logic [HANDLE_W-1:0] issued_count;
  in_item_t            item;

  logic                in_xfer;
  logic                head_ok;
  logic                free_ok;
  logic                room_left;
  logic [HANDLE_W-1:0] bump_handle;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [HANDLE_W-1:0] ram_wdata;
  logic [HANDLE_W-1:0] ram_rdata;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign in_xfer  = in_valid && !in_stall;

  // The head and count are stable between the input transfer and the work
  // cycle, so the link read under the head is started at the transfer.
  assign head_ok     = (free_head != '0) && (free_head <= issued_count);
  assign free_ok     = (item.handle_in != '0) && (item.handle_in <= issued_count);
  assign room_left   = (32'(issued_count) < CAPACITY);
  assign bump_handle = issued_count + HANDLE_W'(1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ADDR_W'(issued_count);
    ram_wdata = '0;
    if (state == S_WORK) begin
      if (item.operation == OP_FREE) begin
        ram_we    = free_ok;
        ram_waddr = ADDR_W'(item.handle_in - HANDLE_W'(1));
        ram_wdata = free_head;
      end else if (!head_ok) begin
        ram_we    = room_left;
        ram_waddr = ADDR_W'(issued_count);
        ram_wdata = '0;
      end
    end
  end

  hfla_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_xfer),
    .raddr (ADDR_W'(free_head - HANDLE_W'(1))),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      free_head    <= '0;
      issued_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_WORK;
          end
        end
        S_WORK: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
          if (item.operation == OP_FREE) begin
            if (free_ok) begin
              free_head <= item.handle_in;
            end
          end else if (head_ok) begin
            free_head <= ram_rdata;
          end else if (room_left) begin
            issued_count <= bump_handle;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers: captured item and result.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item <= in_data;
    end
    if (state == S_WORK) begin
      if (item.operation == OP_FREE) begin
        out_data.handle_out <= '0;
        out_data.status     <= free_ok ? ST_OK : ST_INVALID;
      end else if (head_ok) begin
        out_data.handle_out <= free_head;
        out_data.status     <= ST_OK;
      end else if (room_left) begin
        out_data.handle_out <= bump_handle;
        out_data.status     <= ST_OK;
      end else begin
        out_data.handle_out <= '0;
        out_data.status     <= ST_EXHAUSTED;
      end
    end
  end

endmodule
